// ----- sv/rtpp_pkg.sv -----
// Shared types and constants of the RTP/TS MTU packetizer.
package rtpp_pkg;

   // Packet geometry.
   localparam int unsigned MIN_MTU   = 64;
   localparam int unsigned HDR_BYTES = 12;
   // Width that holds a fill count plus a 16-bit block length.
   localparam int unsigned SUM_W     = 17;

   // Fixed RTP header bytes.
   localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
   localparam logic [7:0] RTP_TYPE_BYTE    = 8'h21;

   // Timestamp conversion: microseconds * 9 / 100 gives 90 kHz ticks.
   localparam int unsigned TS_DIVISOR  = 100;
   localparam int unsigned TIME_W      = 40;
   localparam int unsigned PROD_W      = TIME_W + 4;
   localparam int unsigned DIV_STEP    = 8;
   localparam int unsigned DIV_BITS    = 48;
   localparam int unsigned DIV_CYCLES  = DIV_BITS / DIV_STEP;
   localparam int unsigned DIV_CNT_W   = 3;
   localparam int unsigned DIV_REM_W   = 7;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RTP_ENABLE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAW_MODE       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MTU_BYTES      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEQUENCE_START = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_ID      = 3'd4;

   // Output byte slots of one command, in emission order.
   localparam int unsigned SLOT_COUNT = 15;
   localparam int unsigned SLOT_W     = 4;
   localparam logic [SLOT_W-1:0] SLOT_CLOSE  = 4'd0;
   localparam logic [SLOT_W-1:0] SLOT_VER    = 4'd1;
   localparam logic [SLOT_W-1:0] SLOT_TYPE   = 4'd2;
   localparam logic [SLOT_W-1:0] SLOT_SEQ1   = 4'd3;
   localparam logic [SLOT_W-1:0] SLOT_SEQ0   = 4'd4;
   localparam logic [SLOT_W-1:0] SLOT_TS3    = 4'd5;
   localparam logic [SLOT_W-1:0] SLOT_TS2    = 4'd6;
   localparam logic [SLOT_W-1:0] SLOT_TS1    = 4'd7;
   localparam logic [SLOT_W-1:0] SLOT_TS0    = 4'd8;
   localparam logic [SLOT_W-1:0] SLOT_SSRC3  = 4'd9;
   localparam logic [SLOT_W-1:0] SLOT_SSRC2  = 4'd10;
   localparam logic [SLOT_W-1:0] SLOT_SSRC1  = 4'd11;
   localparam logic [SLOT_W-1:0] SLOT_SSRC0  = 4'd12;
   localparam logic [SLOT_W-1:0] SLOT_HELD   = 4'd13;
   localparam logic [SLOT_W-1:0] SLOT_CUR    = 4'd14;

   // One classified input byte: which bytes it releases and what they carry.
   typedef struct packed {
      logic              close_en;
      logic              hdr_en;
      logic              held_en;
      logic              cur_en;
      logic [7:0]        held_byte;
      logic [7:0]        cur_byte;
      logic [15:0]       seq;
      logic [TIME_W-1:0] tim;
   } cmd_type;

   // One result byte.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_type;

endpackage

// ----- sv/rtp_ts_mtu_packetizer_core.sv -----
// Top level of the RTP/MPEG-2 TS MTU packetizer.
//
//   Channel   Direction  Handshake            Payload
//   req_*     in         push / full          data_byte, block_first, block_last,
//                                             block_length, block_time
//   rsp_*     out        empty / pop          out_byte, packet_end
//   csr_*     in         valid / ready        index, wdata
//
// An input byte is accepted whenever the command queue has room,
// so a steady stream of payload bytes moves at one transfer per cycle.
// Each accepted byte releases zero, one or two bytes, or twelve or thirteen when
// it opens an RTP packet; the emitter sends one result byte per cycle while the
// result buffer has room, so the emitter port sets the rate and the header bytes
// push back on the input. The 90 kHz timestamp is divided out after the command
// loads; bytes ahead of it cover most of the divide, so timestamp bytes may wait.
// Synchronous active-high reset clears all control state and loads the register
// reset values; no clearing pass is needed.
module rtp_ts_mtu_packetizer_core #(
   parameter int unsigned MAX_MTU   = 2048,
   parameter int unsigned CMD_DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   // Payload byte input.
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_block_first,
   input  logic                          req_block_last,
   input  logic [15:0]                   req_block_length,
   input  logic [rtpp_pkg::TIME_W-1:0]   req_block_time,
   // Packet byte output.
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_packet_end,
   // Register writes.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rtpp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata
);

   // Configuration registers. A write to the sequence start index is not stored;
   // it only reloads the running sequence counter in the front end.
   logic        rtp_enable_ff, rtp_enable_in;
   logic        raw_mode_ff, raw_mode_in;
   logic [11:0] mtu_bytes_ff, mtu_bytes_in;
   logic [31:0] source_id_ff, source_id_in;
   logic        csr_write;
   logic        seq_load;

   rtpp_pkg::cmd_type cq_push_data;
   rtpp_pkg::cmd_type cq_pop_data;
   logic              cq_push;
   logic              cq_full;
   logic              cq_pop;
   logic              cq_valid;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      rtp_enable_in = rtp_enable_ff;
      raw_mode_in   = raw_mode_ff;
      mtu_bytes_in  = mtu_bytes_ff;
      source_id_in  = source_id_ff;
      seq_load      = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            rtpp_pkg::CSR_RTP_ENABLE:     rtp_enable_in = csr_wdata[0];
            rtpp_pkg::CSR_RAW_MODE:       raw_mode_in   = csr_wdata[0];
            rtpp_pkg::CSR_MTU_BYTES:      mtu_bytes_in  = csr_wdata[11:0];
            rtpp_pkg::CSR_SEQUENCE_START: seq_load      = 1'b1;
            rtpp_pkg::CSR_SOURCE_ID:      source_id_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rtp_enable_ff <= 1'b0;
         raw_mode_ff   <= 1'b0;
         mtu_bytes_ff  <= 12'd1500;
         source_id_ff  <= '0;
      end else begin
         rtp_enable_ff <= rtp_enable_in;
         raw_mode_ff   <= raw_mode_in;
         mtu_bytes_ff  <= mtu_bytes_in;
         source_id_ff  <= source_id_in;
      end
   end

   // The front end classifies each byte against the open packet and queues
   // a command naming the bytes it releases.
   rtpp_front #(
      .MAX_MTU (MAX_MTU)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .rtp_enable       (rtp_enable_ff),
      .raw_mode         (raw_mode_ff),
      .mtu_bytes        (mtu_bytes_ff),
      .seq_load         (seq_load),
      .seq_value        (csr_wdata[15:0]),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_block_first  (req_block_first),
      .req_block_last   (req_block_last),
      .req_block_length (req_block_length),
      .req_block_time   (req_block_time),
      .cq_push          (cq_push),
      .cq_full          (cq_full),
      .cq_data          (cq_push_data)
   );

   rtpp_cmd_fifo #(
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cq_push),
      .push_data (cq_push_data),
      .full      (cq_full),
      .pop       (cq_pop),
      .valid     (cq_valid),
      .pop_data  (cq_pop_data)
   );

   // The back end turns each command into bytes, one transfer per cycle unless stalled.
   rtpp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .source_id      (source_id_ff),
      .cq_valid       (cq_valid),
      .cq_data        (cq_pop_data),
      .cq_pop         (cq_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_packet_end (rsp_packet_end)
   );

endmodule

// ----- sv/rtpp_front.sv -----
// Front end: accepts payload bytes, tracks packet state, issues byte commands.
module rtpp_front #(
   parameter int unsigned MAX_MTU = 2048
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rtp_enable,
   input  logic                      raw_mode,
   input  logic [11:0]               mtu_bytes,
   input  logic                      seq_load,
   input  logic [15:0]               seq_value,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_block_first,
   input  logic                      req_block_last,
   input  logic [15:0]               req_block_length,
   input  logic [rtpp_pkg::TIME_W-1:0] req_block_time,
   output logic                      cq_push,
   input  logic                      cq_full,
   output rtpp_pkg::cmd_type         cq_data
);

   localparam int unsigned FILL_W = $clog2(MAX_MTU + 1);
   localparam int unsigned SUM_W  = rtpp_pkg::SUM_W;

   logic [FILL_W-1:0] packet_fill_ff, packet_fill_in;
   logic              packet_open_ff, packet_open_in;
   logic              held_valid_ff, held_valid_in;
   logic [7:0]        held_byte_ff, held_byte_in;
   logic              block_spilled_ff, block_spilled_in;
   logic [15:0]       seq_ff, seq_in;

   logic              accept;
   logic [SUM_W-1:0]  mtu_eff;

   assign req_full = cq_full;
   assign accept   = req_push && !cq_full;

   always_comb begin
      if (SUM_W'(mtu_bytes) < SUM_W'(rtpp_pkg::MIN_MTU)) begin
         mtu_eff = SUM_W'(rtpp_pkg::MIN_MTU);
      end else if (SUM_W'(mtu_bytes) > SUM_W'(MAX_MTU)) begin
         mtu_eff = SUM_W'(MAX_MTU);
      end else begin
         mtu_eff = SUM_W'(mtu_bytes);
      end
   end

   always_comb begin
      logic             close_hit;
      logic             open_a;
      logic             held_a;
      logic             spill_a;
      logic [SUM_W-1:0] fill_b;
      logic [SUM_W-1:0] fill_c;

      close_hit        = 1'b0;
      open_a           = packet_open_ff;
      held_a           = held_valid_ff;
      spill_a          = block_spilled_ff;
      fill_b           = SUM_W'(packet_fill_ff);
      fill_c           = fill_b;
      packet_fill_in   = packet_fill_ff;
      packet_open_in   = packet_open_ff;
      held_valid_in    = held_valid_ff;
      held_byte_in     = held_byte_ff;
      block_spilled_in = block_spilled_ff;
      seq_in           = seq_load ? seq_value : seq_ff;

      cq_data           = '0;
      cq_data.held_byte = held_byte_ff;
      cq_data.cur_byte  = req_data_byte;
      cq_data.seq       = seq_ff;
      cq_data.tim       = req_block_time;

      if (accept) begin
         if (raw_mode) begin
            // Every block is one packet: the held byte ends the previous one.
            cq_data.close_en = req_block_first && held_valid_ff;
            cq_data.held_en  = held_valid_ff && !req_block_first;
            cq_data.cur_en   = req_block_last;
            held_valid_in    = !req_block_last;
            if (!req_block_last) begin
               held_byte_in = req_data_byte;
            end
            packet_open_in   = !req_block_last;
            packet_fill_in   = '0;
            block_spilled_in = 1'b0;
         end else begin
            if (req_block_first) begin
               spill_a   = 1'b0;
               close_hit = packet_open_ff &&
                           (SUM_W'(packet_fill_ff) + SUM_W'(req_block_length) > mtu_eff);
            end
            cq_data.close_en = close_hit && held_valid_ff;
            open_a = packet_open_ff && !close_hit;
            held_a = held_valid_ff && !close_hit;

            if (!open_a) begin
               // Opening a packet: header first when RTP is on.
               held_a         = 1'b0;
               cq_data.hdr_en = rtp_enable;
               fill_b         = rtp_enable ? SUM_W'(rtpp_pkg::HDR_BYTES) : '0;
               if (rtp_enable) begin
                  seq_in = seq_ff + 16'd1;
               end
            end
            cq_data.held_en = held_a;
            fill_c = fill_b + SUM_W'(1);

            if (fill_c >= mtu_eff) begin
               cq_data.cur_en   = 1'b1;
               packet_open_in   = 1'b0;
               packet_fill_in   = '0;
               block_spilled_in = !req_block_last;
               held_valid_in    = 1'b0;
            end else if (req_block_last && spill_a) begin
               cq_data.cur_en   = 1'b1;
               packet_open_in   = 1'b0;
               packet_fill_in   = '0;
               block_spilled_in = 1'b0;
               held_valid_in    = 1'b0;
            end else begin
               held_byte_in     = req_data_byte;
               held_valid_in    = 1'b1;
               packet_open_in   = 1'b1;
               packet_fill_in   = FILL_W'(fill_c);
               block_spilled_in = req_block_last ? 1'b0 : spill_a;
            end
         end
      end

      cq_push = accept &&
                (cq_data.close_en || cq_data.hdr_en || cq_data.held_en || cq_data.cur_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_fill_ff   <= '0;
         packet_open_ff   <= 1'b0;
         held_valid_ff    <= 1'b0;
         held_byte_ff     <= '0;
         block_spilled_ff <= 1'b0;
         seq_ff           <= '0;
      end else begin
         packet_fill_ff   <= packet_fill_in;
         packet_open_ff   <= packet_open_in;
         held_valid_ff    <= held_valid_in;
         held_byte_ff     <= held_byte_in;
         block_spilled_ff <= block_spilled_in;
         seq_ff           <= seq_in;
      end
   end

   a_closed_is_empty: assert property (@(posedge clock) disable iff (reset)
      !packet_open_ff |-> packet_fill_ff == '0)
      else $error("closed packet has a nonzero fill");

   a_held_needs_open: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> packet_open_ff)
      else $error("byte held back without an open packet");

endmodule

// ----- sv/rtpp_cmd_fifo.sv -----
// Short command queue between the front end and the byte emitter.
module rtpp_cmd_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rtpp_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output rtpp_pkg::cmd_type pop_data
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   rtpp_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign valid    = count_ff != '0;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("command queue count beyond depth");

endmodule

// ----- sv/rtpp_back.sv -----
// Back end: expands commands into packet bytes and computes the RTP timestamp.
module rtpp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         source_id,
   input  logic                cq_valid,
   input  rtpp_pkg::cmd_type   cq_data,
   output logic                cq_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_packet_end
);

   localparam int unsigned NS     = rtpp_pkg::SLOT_COUNT;
   localparam int unsigned SW     = rtpp_pkg::SLOT_W;
   localparam int unsigned DB     = rtpp_pkg::DIV_BITS;
   localparam int unsigned RW     = rtpp_pkg::DIV_REM_W;
   localparam int unsigned CW     = rtpp_pkg::DIV_CNT_W;

   rtpp_pkg::cmd_type cmd_ff, cmd_in;
   logic [NS-1:0]     mask_ff, mask_in;
   logic [DB-1:0]     div_num_ff, div_num_in;
   logic [RW-1:0]     div_rem_ff, div_rem_in;
   logic [31:0]       div_quo_ff, div_quo_in;
   logic [CW-1:0]     div_cnt_ff, div_cnt_in;

   rtpp_pkg::out_type ob_head_ff, ob_head_in;
   rtpp_pkg::out_type ob_tail_ff, ob_tail_in;
   logic [1:0]        ob_cnt_ff, ob_cnt_in;

   logic [NS-1:0]     lowest;
   logic [SW-1:0]     slot;
   logic              ts_slot;
   logic              emit;
   logic              load;
   logic [NS-1:0]     mask_after;
   rtpp_pkg::out_type emit_item;
   logic              ob_pop;

   // Lowest pending slot is the next byte to send.
   always_comb begin
      lowest = mask_ff & (~mask_ff + NS'(1));
      slot   = '0;
      for (int i = 0; i < NS; i++) begin
         if (lowest[i]) begin
            slot = SW'(i);
         end
      end
   end

   assign ts_slot = (slot == rtpp_pkg::SLOT_TS3) || (slot == rtpp_pkg::SLOT_TS2) ||
                    (slot == rtpp_pkg::SLOT_TS1) || (slot == rtpp_pkg::SLOT_TS0);
   assign emit = (mask_ff != '0) && (ob_cnt_ff != 2'd2) &&
                 !(ts_slot && (div_cnt_ff != '0));
   assign mask_after = emit ? (mask_ff & ~lowest) : mask_ff;
   assign load   = (mask_after == '0) && cq_valid;
   assign cq_pop = load;

   always_comb begin
      emit_item.last = 1'b0;
      unique case (slot)
         rtpp_pkg::SLOT_CLOSE: begin
            emit_item.data = cmd_ff.held_byte;
            emit_item.last = 1'b1;
         end
         rtpp_pkg::SLOT_VER:   emit_item.data = rtpp_pkg::RTP_VERSION_BYTE;
         rtpp_pkg::SLOT_TYPE:  emit_item.data = rtpp_pkg::RTP_TYPE_BYTE;
         rtpp_pkg::SLOT_SEQ1:  emit_item.data = cmd_ff.seq[15:8];
         rtpp_pkg::SLOT_SEQ0:  emit_item.data = cmd_ff.seq[7:0];
         rtpp_pkg::SLOT_TS3:   emit_item.data = div_quo_ff[31:24];
         rtpp_pkg::SLOT_TS2:   emit_item.data = div_quo_ff[23:16];
         rtpp_pkg::SLOT_TS1:   emit_item.data = div_quo_ff[15:8];
         rtpp_pkg::SLOT_TS0:   emit_item.data = div_quo_ff[7:0];
         rtpp_pkg::SLOT_SSRC3: emit_item.data = source_id[31:24];
         rtpp_pkg::SLOT_SSRC2: emit_item.data = source_id[23:16];
         rtpp_pkg::SLOT_SSRC1: emit_item.data = source_id[15:8];
         rtpp_pkg::SLOT_SSRC0: emit_item.data = source_id[7:0];
         rtpp_pkg::SLOT_HELD:  emit_item.data = cmd_ff.held_byte;
         rtpp_pkg::SLOT_CUR: begin
            emit_item.data = cmd_ff.cur_byte;
            emit_item.last = 1'b1;
         end
         default:              emit_item.data = '0;
      endcase
   end

   // Command register, slot mask and the timestamp divider.
   always_comb begin
      logic [RW:0]               r;
      logic [DB-1:0]             num;
      logic [31:0]               quo;
      logic [rtpp_pkg::PROD_W-1:0] prod;

      cmd_in     = cmd_ff;
      mask_in    = mask_after;
      div_num_in = div_num_ff;
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_cnt_in = div_cnt_ff;
      r          = '0;
      num        = div_num_ff;
      quo        = div_quo_ff;
      // Times nine as shift and add.
      prod = {cq_data.tim, 3'b000} + rtpp_pkg::PROD_W'(cq_data.tim);

      if (div_cnt_ff != '0) begin
         // Long division by the tick divisor, a byte of dividend per cycle.
         r = {1'b0, div_rem_ff};
         for (int i = 0; i < rtpp_pkg::DIV_STEP; i++) begin
            r   = {r[RW-1:0], num[DB-1]};
            num = {num[DB-2:0], 1'b0};
            if (r >= (RW+1)'(rtpp_pkg::TS_DIVISOR)) begin
               r   = r - (RW+1)'(rtpp_pkg::TS_DIVISOR);
               quo = {quo[30:0], 1'b1};
            end else begin
               quo = {quo[30:0], 1'b0};
            end
         end
         div_num_in = num;
         div_rem_in = r[RW-1:0];
         div_quo_in = quo;
         div_cnt_in = div_cnt_ff - CW'(1);
      end

      if (load) begin
         cmd_in = cq_data;
         mask_in = '0;
         mask_in[rtpp_pkg::SLOT_CLOSE] = cq_data.close_en;
         mask_in[rtpp_pkg::SLOT_SSRC0:rtpp_pkg::SLOT_VER] = {12{cq_data.hdr_en}};
         mask_in[rtpp_pkg::SLOT_HELD]  = cq_data.held_en;
         mask_in[rtpp_pkg::SLOT_CUR]   = cq_data.cur_en;
         if (cq_data.hdr_en) begin
            div_num_in = DB'(prod);
            div_rem_in = '0;
            div_quo_in = '0;
            div_cnt_in = CW'(rtpp_pkg::DIV_CYCLES);
         end
      end
   end

   // Two-entry result buffer.
   assign ob_pop         = rsp_pop && (ob_cnt_ff != 2'd0);
   assign rsp_empty      = ob_cnt_ff == 2'd0;
   assign rsp_out_byte   = ob_head_ff.data;
   assign rsp_packet_end = ob_head_ff.last;

   always_comb begin
      ob_head_in = ob_head_ff;
      ob_tail_in = ob_tail_ff;
      ob_cnt_in  = ob_cnt_ff;
      if (ob_pop && emit) begin
         if (ob_cnt_ff == 2'd1) begin
            ob_head_in = emit_item;
         end else begin
            ob_head_in = ob_tail_ff;
            ob_tail_in = emit_item;
         end
      end else if (ob_pop) begin
         ob_head_in = ob_tail_ff;
         ob_cnt_in  = ob_cnt_ff - 2'd1;
      end else if (emit) begin
         if (ob_cnt_ff == 2'd0) begin
            ob_head_in = emit_item;
         end else begin
            ob_tail_in = emit_item;
         end
         ob_cnt_in = ob_cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      ob_head_ff <= ob_head_in;
      ob_tail_ff <= ob_tail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff    <= '0;
         div_cnt_ff <= '0;
         ob_cnt_ff  <= '0;
      end else begin
         mask_ff    <= mask_in;
         div_cnt_ff <= div_cnt_in;
         ob_cnt_ff  <= ob_cnt_in;
      end
   end

   a_div_idle_on_load: assert property (@(posedge clock) disable iff (reset)
      load |-> div_cnt_ff == '0)
      else $error("new command loaded while timestamp divide still running");

   a_loaded_not_empty: assert property (@(posedge clock) disable iff (reset)
      load |=> mask_ff != '0)
      else $error("command loaded with no bytes to send");

   a_buffer_bound: assert property (@(posedge clock) disable iff (reset)
      ob_cnt_ff != 2'd3)
      else $error("result buffer overfilled");

endmodule

// ----- dv/rtp_ts_mtu_packetizer_core_tb.sv -----
// Self-checking testbench for the RTP/MPEG-2 TS MTU packetizer core.
`timescale 1ns / 100ps

module rtp_ts_mtu_packetizer_core_tb;

   // Largest MTU the core is built for; larger register values are clamped to it.
   localparam int unsigned MTU_CEILING  = 2048;
   // Cycles to let pass after the last expected byte, so that a byte still
   // held inside the core or a divide in flight has settled.
   localparam int          SETTLE_CYCLES = 40;
   // Hard stop for the whole run; far above the slowest legal run.
   localparam int          CYCLE_LIMIT   = 400000;
   // Only the first mismatches are printed; all of them are counted.
   localparam int          MAX_REPORTS   = 40;

   // One payload byte as it is offered on the req_ channel.
   typedef struct {
      logic [7:0]                  data;
      logic                        first;
      logic                        last;
      logic [15:0]                 length;
      logic [rtpp_pkg::TIME_W-1:0] stamp;
   } req_beat_type;

   // The scoreboard keeps its own copy of the packetizer state and registers.
   // Each accepted payload byte is run through the packing rules and the
   // packet bytes it releases are queued; each popped byte is checked
   // against the oldest queued one.
   class packet_scoreboard;
      bit                rtp_on;
      bit                raw_on;
      bit [11:0]         mtu_reg = 12'd1500;
      bit [31:0]         ssrc;
      bit [15:0]         seq_num;
      int unsigned       fill;
      bit                pkt_open;
      bit                held_ok;
      bit [7:0]          held;
      bit                spilled;
      rtpp_pkg::out_type expected_bytes[$];
      int                mismatches;
      int                checked;

      task report_mismatch(input string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t ns: mismatch on packet byte %0d: %s", $time, checked, what);
      endtask

      function void push_expected(input logic [7:0] data, input logic last);
         rtpp_pkg::out_type b;
         b.data = data;
         b.last = last;
         expected_bytes.push_back(b);
      endfunction

      function void write_reg(input logic [rtpp_pkg::CSR_INDEX_W-1:0] index,
                              input logic [31:0] wdata);
         unique case (index)
            rtpp_pkg::CSR_RTP_ENABLE:     rtp_on  = wdata[0];
            rtpp_pkg::CSR_RAW_MODE:       raw_on  = wdata[0];
            rtpp_pkg::CSR_MTU_BYTES:      mtu_reg = wdata[11:0];
            rtpp_pkg::CSR_SEQUENCE_START: seq_num = wdata[15:0];
            rtpp_pkg::CSR_SOURCE_ID:      ssrc    = wdata;
            default: ;
         endcase
      endfunction

      // Works out the packet bytes released by one accepted payload byte.
      function void note_byte(input req_beat_type beat);
         int unsigned limit;
         logic [63:0] ticks;
         logic [31:0] ts;

         if (mtu_reg < rtpp_pkg::MIN_MTU)
            limit = rtpp_pkg::MIN_MTU;
         else if (mtu_reg > MTU_CEILING)
            limit = MTU_CEILING;
         else
            limit = mtu_reg;

         // Raw mode: one packet per block, no header, no size limit.
         if (raw_on) begin
            if (beat.first && held_ok) begin
               push_expected(held, 1'b1);
               held_ok = 1'b0;
            end
            if (held_ok)
               push_expected(held, 1'b0);
            if (beat.last) begin
               push_expected(beat.data, 1'b1);
               held_ok = 1'b0;
            end else begin
               held    = beat.data;
               held_ok = 1'b1;
            end
            pkt_open = held_ok;
            fill     = 0;
            spilled  = 1'b0;
            return;
         end

         // A new block that does not fit closes the open packet first.
         if (beat.first) begin
            spilled = 1'b0;
            if (pkt_open && (fill + int'(beat.length) > limit)) begin
               if (held_ok)
                  push_expected(held, 1'b1);
               held_ok  = 1'b0;
               pkt_open = 1'b0;
            end
         end

         if (!pkt_open) begin
            pkt_open = 1'b1;
            fill     = 0;
            held_ok  = 1'b0;
            if (rtp_on) begin
               ticks = ({24'd0, beat.stamp} * 64'd9) / 64'd100;
               ts    = ticks[31:0];
               push_expected(rtpp_pkg::RTP_VERSION_BYTE, 1'b0);
               push_expected(rtpp_pkg::RTP_TYPE_BYTE, 1'b0);
               push_expected(seq_num[15:8], 1'b0);
               push_expected(seq_num[7:0], 1'b0);
               seq_num = seq_num + 16'd1;
               push_expected(ts[31:24], 1'b0);
               push_expected(ts[23:16], 1'b0);
               push_expected(ts[15:8], 1'b0);
               push_expected(ts[7:0], 1'b0);
               push_expected(ssrc[31:24], 1'b0);
               push_expected(ssrc[23:16], 1'b0);
               push_expected(ssrc[15:8], 1'b0);
               push_expected(ssrc[7:0], 1'b0);
               fill = rtpp_pkg::HDR_BYTES;
            end
         end

         if (held_ok)
            push_expected(held, 1'b0);
         held_ok = 1'b0;
         fill++;

         if (fill >= limit) begin
            // Packet is full; a block that goes on has spilled.
            push_expected(beat.data, 1'b1);
            pkt_open = 1'b0;
            fill     = 0;
            spilled  = !beat.last;
         end else if (beat.last && spilled) begin
            // End of a block that already filled an earlier packet.
            push_expected(beat.data, 1'b1);
            pkt_open = 1'b0;
            fill     = 0;
            spilled  = 1'b0;
         end else begin
            held    = beat.data;
            held_ok = 1'b1;
            if (beat.last)
               spilled = 1'b0;
         end
      endfunction

      task check_byte(input logic [7:0] data, input logic last);
         rtpp_pkg::out_type want;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h end %0b", data, last));
         end else begin
            want = expected_bytes.pop_front();
            if (data !== want.data)
               report_mismatch($sformatf("out_byte %02h, expected %02h", data, want.data));
            if (last !== want.last)
               report_mismatch($sformatf("packet_end %0b, expected %0b", last, want.last));
         end
         checked++;
      endtask
   endclass

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_push;
   logic                             req_full;
   logic [7:0]                       req_data_byte;
   logic                             req_block_first;
   logic                             req_block_last;
   logic [15:0]                      req_block_length;
   logic [rtpp_pkg::TIME_W-1:0]      req_block_time;
   logic                             rsp_empty;
   logic                             rsp_pop;
   logic [7:0]                       rsp_out_byte;
   logic                             rsp_packet_end;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [rtpp_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [31:0]                      csr_wdata;

   packet_scoreboard scb = new();

   // Stimulus of the current phase, oldest byte first.
   req_beat_type stim_beats[$];
   // Idle percentages of the two sides and the receiver's hold-off counter.
   int        send_gap_pct;
   int        recv_gap_pct;
   int        hold_left;
   int        cycle_count;

   rtp_ts_mtu_packetizer_core #(
      .MAX_MTU (MTU_CEILING)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_block_first  (req_block_first),
      .req_block_last   (req_block_last),
      .req_block_length (req_block_length),
      .req_block_time   (req_block_time),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_packet_end   (rsp_packet_end),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // 4 ns clock: low for 2 ns, then high for 2 ns.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Every transfer on the three channels is seen here at the rising edge,
   // in one process, so the scoreboard never depends on process order.
   // Register writes and payload bytes never share a cycle.
   always @(posedge clock) begin
      req_beat_type seen;
      if (!reset) begin
         if (csr_valid && csr_ready)
            scb.write_reg(csr_index, csr_wdata);
         if (req_push && !req_full) begin
            seen.data   = req_data_byte;
            seen.first  = req_block_first;
            seen.last   = req_block_last;
            seen.length = req_block_length;
            seen.stamp  = req_block_time;
            scb.note_byte(seen);
         end
         if (rsp_pop && !rsp_empty)
            scb.check_byte(rsp_out_byte, rsp_packet_end);
      end
   end

   // Receiver: pops at random, or not at all while a hold-off is counting down.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
   end

   // Watchdog: a stuck handshake or a lost byte ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d packet bytes still outstanding",
                  cycle_count, scb.expected_bytes.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // One register write transfer; inputs change on the falling edge.
   task automatic write_csr(input logic [rtpp_pkg::CSR_INDEX_W-1:0] index,
                            input logic [31:0] wdata);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= wdata;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_regs(input bit rtp, input bit raw, input logic [11:0] mtu,
                               input logic [15:0] seq, input logic [31:0] ssrc);
      write_csr(rtpp_pkg::CSR_RTP_ENABLE, {31'd0, rtp});
      write_csr(rtpp_pkg::CSR_RAW_MODE, {31'd0, raw});
      write_csr(rtpp_pkg::CSR_MTU_BYTES, {20'd0, mtu});
      write_csr(rtpp_pkg::CSR_SEQUENCE_START, {16'd0, seq});
      write_csr(rtpp_pkg::CSR_SOURCE_ID, ssrc);
   endtask

   // Offers one payload byte, possibly after some idle cycles, and returns
   // at the rising edge where it was accepted. push is assigned once per
   // falling edge, so back-to-back bytes keep it high.
   task automatic push_beat(input req_beat_type beat);
      bit taken;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push         <= 1'b1;
      req_data_byte    <= beat.data;
      req_block_first  <= beat.first;
      req_block_last   <= beat.last;
      req_block_length <= beat.length;
      req_block_time   <= beat.stamp;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         if (!req_full)
            taken = 1'b1;
         else
            @(negedge clock);
      end
   endtask

   task automatic send_beats(input int count);
      for (int i = 0; i < count && stim_beats.size() > 0; i++)
         push_beat(stim_beats.pop_front());
   endtask

   // Stops offering bytes and waits until every expected packet byte has
   // been popped, then lets the core settle before registers change.
   task automatic drain_results();
      @(negedge clock);
      req_push <= 1'b0;
      while (scb.expected_bytes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic req_beat_type make_beat(input logic [7:0] data, input bit first,
                                              input bit last, input logic [15:0] length,
                                              input logic [rtpp_pkg::TIME_W-1:0] stamp);
      req_beat_type b;
      b.data   = data;
      b.first  = first;
      b.last   = last;
      b.length = length;
      b.stamp  = stamp;
      return b;
   endfunction

   function automatic logic [rtpp_pkg::TIME_W-1:0] random_stamp();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return rtpp_pkg::TIME_W'({$urandom(), $urandom()});
      endcase
   endfunction

   // Appends one block. Most blocks are well formed with random content;
   // the rest carry a wrong length, lack their last byte, or lack their
   // first byte. Bytes other than the first carry a random length field,
   // which the core ignores.
   task automatic gen_block();
      int  kind;
      int  count;
      bit  has_first;
      bit  has_last;
      logic [15:0] len_field;

      kind      = $urandom_range(0, 99);
      has_first = 1'b1;
      has_last  = 1'b1;
      if (kind < 78) begin
         count     = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
         len_field = count[15:0];
      end else if (kind < 86) begin
         count     = $urandom_range(1, 12);
         len_field = 16'($urandom_range(0, 65535));
      end else if (kind < 93) begin
         count     = $urandom_range(1, 12);
         len_field = count[15:0];
         has_last  = 1'b0;
      end else begin
         count     = $urandom_range(1, 12);
         len_field = count[15:0];
         has_first = 1'b0;
         has_last  = 1'($urandom_range(0, 1));
      end
      for (int i = 0; i < count; i++)
         stim_beats.push_back(make_beat(8'($urandom_range(0, 255)),
                                        has_first && (i == 0),
                                        has_last && (i == count - 1),
                                        (i == 0) ? len_field : 16'($urandom_range(0, 65535)),
                                        random_stamp()));
   endtask

   initial begin
      bit          rtp;
      bit          raw;
      logic [11:0] mtu;
      int          budget;

      req_push         = 1'b0;
      req_data_byte    = '0;
      req_block_first  = 1'b0;
      req_block_last   = 1'b0;
      req_block_length = '0;
      req_block_time   = '0;
      rsp_pop          = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = rtpp_pkg::CSR_RTP_ENABLE;
      csr_wdata        = '0;
      send_gap_pct     = 24;
      recv_gap_pct     = 53;
      hold_left        = 0;
      cycle_count      = 0;
      reset            = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, RTP on. An MTU of zero is clamped to the minimum,
      // the sequence starts at its top value so the first header wraps it,
      // and the extremes of data, time and length all show up.
      program_regs(1'b1, 1'b0, 12'd0, 16'hffff, 32'hffff_ffff);
      stim_beats.push_back(make_beat(8'hff, 1'b1, 1'b0, 16'd3, '1));
      stim_beats.push_back(make_beat(8'h00, 1'b0, 1'b0, 16'hffff, '0));
      stim_beats.push_back(make_beat(8'hff, 1'b0, 1'b1, 16'd0, '0));
      // A block that cannot fit closes the open packet before its header.
      stim_beats.push_back(make_beat(8'h5a, 1'b1, 1'b0, 16'hffff, '0));
      stim_beats.push_back(make_beat(8'ha5, 1'b0, 1'b0, 16'd1, '1));
      // The block above never ends; a new first byte just starts a new block.
      stim_beats.push_back(make_beat(8'h33, 1'b1, 1'b1, 16'd1, 40'd12345));
      // A block that claims zero length always fits.
      stim_beats.push_back(make_beat(8'h01, 1'b1, 1'b1, 16'd0, 40'd1));
      // A byte without a first flag joins the open packet.
      stim_beats.push_back(make_beat(8'h80, 1'b0, 1'b0, 16'd7, 40'd1000));
      send_beats(stim_beats.size());
      drain_results();

      // Switch to raw mode with a byte still held: it carries over.
      write_csr(rtpp_pkg::CSR_RAW_MODE, 32'd1);
      stim_beats.push_back(make_beat(8'h11, 1'b0, 1'b0, 16'd2, 40'd5));
      stim_beats.push_back(make_beat(8'h22, 1'b1, 1'b0, 16'd2, 40'd6));
      stim_beats.push_back(make_beat(8'h33, 1'b0, 1'b1, 16'd2, 40'd7));
      stim_beats.push_back(make_beat(8'h44, 1'b1, 1'b1, 16'd1, 40'd8));
      stim_beats.push_back(make_beat(8'h55, 1'b1, 1'b0, 16'd2, 40'd9));
      // In raw mode a first byte with no last byte before it closes the
      // previous packet on the held byte.
      stim_beats.push_back(make_beat(8'h66, 1'b1, 1'b0, 16'd2, 40'd10));
      send_beats(stim_beats.size());
      drain_results();

      // Back to packing, no header, MTU above the ceiling so it clamps.
      program_regs(1'b0, 1'b0, 12'hfff, 16'h0000, 32'h0000_0000);
      stim_beats.push_back(make_beat(8'h77, 1'b0, 1'b1, 16'd2, 40'd11));
      stim_beats.push_back(make_beat(8'h88, 1'b1, 1'b1, 16'hffff, 40'd12));
      stim_beats.push_back(make_beat(8'h99, 1'b1, 1'b0, 16'd2, 40'd13));
      stim_beats.push_back(make_beat(8'haa, 1'b0, 1'b1, 16'd2, '1));
      send_beats(stim_beats.size());
      drain_results();

      // Random part in six phases. The first two idle the sender lightly and
      // the receiver heavily, the next two the other way round, the last two
      // not at all. Registers change only between phases, with the open
      // packet and held byte carried across.
      for (int sp = 0; sp < 6; sp++) begin
         send_gap_pct = (sp < 2) ? 24 : (sp < 4) ? 53 : 0;
         recv_gap_pct = (sp < 2) ? 53 : (sp < 4) ? 24 : 0;
         budget       = 32;
         case (sp)
            0: begin rtp = 1'b1; raw = 1'b0; mtu = 12'd64; end
            1: begin rtp = 1'b0; raw = 1'b0; mtu = 12'd65; end
            2: begin rtp = 1'b1; raw = 1'b0; mtu = 12'd2048; budget = 44; end
            3: begin rtp = 1'b1; raw = 1'b0; mtu = 12'd0; end
            4: begin rtp = 1'b0; raw = 1'b1; mtu = 12'hfff; end
            default: begin rtp = 1'b1; raw = 1'b0; mtu = 12'($urandom_range(64, 120)); end
         endcase
         program_regs(rtp, raw, mtu, 16'($urandom_range(0, 65535)), $urandom());

         // After the large-MTU phase the packet may hold more than the new
         // MTU; leading bytes without a first flag make it close at the
         // next byte rather than ahead of a new block.
         if (sp == 3 || sp == 5) begin
            for (int i = 0; i < 3; i++)
               stim_beats.push_back(make_beat(8'($urandom_range(0, 255)), 1'b0, i == 2,
                                              16'($urandom_range(0, 65535)),
                                              random_stamp()));
         end
         while (stim_beats.size() < budget)
            gen_block();

         // The receiver stops for a long stretch while bytes keep coming,
         // so the core fills up and pushes back on its input.
         if (sp == 0)
            hold_left = 150;
         // Halfway through, the sender waits until every packet byte is out.
         if (sp == 2) begin
            send_beats(stim_beats.size() / 2);
            drain_results();
         end
         send_beats(stim_beats.size());
         drain_results();
      end

      if (scb.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
